FILE: rtl/twcm_pkg.sv
`default_nettype none

package twcm_pkg;

    localparam int TEX_LOG2_DEFAULT = 6;
    localparam int NUM_TEXTURES     = 4;
    localparam int TEX_SEL_W        = 2;

    localparam int SCREEN_H_W  = 12;
    localparam int TEXEL_C_W   = 6;
    localparam int COLOR_W     = 32;
    localparam int COLUMN_W    = 11;
    localparam int ROW_W       = 12;
    localparam int PIX_Y_W     = 11;
    localparam int FRAC_W      = 16;
    localparam int LINE_H_W    = 16;
    localparam int POS_W       = 40;
    localparam int POS_FRAC_W  = 16;
    localparam int OFF_W       = 18;

    localparam logic [SCREEN_H_W-1:0] SCREEN_H_RESET = 12'd480;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;

    localparam logic [TEX_SEL_W-1:0] TEX_NORTH = 2'd0;
    localparam logic [TEX_SEL_W-1:0] TEX_SOUTH = 2'd1;
    localparam logic [TEX_SEL_W-1:0] TEX_EAST  = 2'd2;
    localparam logic [TEX_SEL_W-1:0] TEX_WEST  = 2'd3;

    typedef struct packed {
        logic                start;
        logic [LINE_H_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

    // floor(c*4/5) through a reciprocal, exact for all 8-bit inputs
    function automatic logic [7:0] shade_channel(input logic [7:0] c);
        logic [21:0] prod;
        begin
            prod = 22'(c) * 22'd13108;
            return prod[21:14];
        end
    endfunction

    function automatic logic [COLOR_W-1:0] shade_color(input logic [COLOR_W-1:0] c);
        begin
            return {c[31:24], shade_channel(c[23:16]), shade_channel(c[15:8]),
                    shade_channel(c[7:0])};
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/twcm_ram.sv
`default_nettype none

module twcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/twcm_div.sv
`default_nettype none

module twcm_div #(
    parameter int TEX_LOG2 = twcm_pkg::TEX_LOG2_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire twcm_pkg::div_req_t   req,
    output twcm_pkg::div_rsp_t        rsp,
    output logic [TEX_LOG2+16:0]      quotient
);

    import twcm_pkg::*;

    localparam int Q_W   = TEX_LOG2 + 17;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [LINE_H_W-1:0] rem_reg;
    logic [Q_W-1:0]      quo_reg;
    logic [LINE_H_W-1:0] divisor_reg;

    logic [LINE_H_W:0]   rem_shift;
    logic [LINE_H_W:0]   rem_sub;
    logic                fits;

    assign rem_shift = {rem_reg, quo_reg[Q_W-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend is the single bit 1 << (16 + TEX_LOG2), shifted out of the quotient register
    always_ff @(posedge aclk) begin
        if (req.start) begin
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
            quo_reg     <= {1'b1, {(Q_W-1){1'b0}}};
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[LINE_H_W-1:0] : rem_shift[LINE_H_W-1:0];
            quo_reg <= {quo_reg[Q_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/textured_wall_column_mapper.sv
// Raycaster wall column texture mapper. Load beats (opcode 0) write one ARGB texel into a
// four-texture store (north, south, east, west, each 2**TEX_LOG2 square) and are taken one per
// cycle while s_ready is high. A start beat (opcode 1) picks the texture and texture column, then
// computes the row step 2**TEX_LOG2 / wall height (Q7.16 by default) in a one-bit-per-cycle
// restoring divider and the start position with one multiply; s_ready stays low after a start
// until the divide and multiply states are done. Pixel beats (opcode 2) stream one per cycle
// through the synchronous texture RAM while the output does not stall, and each result passes
// through the RAM read and the output register; a pixel beat with no active strip, and opcode 3,
// give no result. North and east texels are darkened to 4/5 per color channel. The texture store
// has no reset: pixels must only read texels that were loaded. screen_height (reset 480) is
// written through cfg_wr_en and cfg_wr_data and must only change while the block is idle.
`default_nettype none

module textured_wall_column_mapper #(
    parameter int TEX_LOG2 = twcm_pkg::TEX_LOG2_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic [twcm_pkg::SCREEN_H_W-1:0]    cfg_wr_data,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_opcode,
    input  wire logic [twcm_pkg::TEX_SEL_W-1:0]     s_texture_select,
    input  wire logic [twcm_pkg::TEXEL_C_W-1:0]     s_texel_col,
    input  wire logic [twcm_pkg::TEXEL_C_W-1:0]     s_texel_row,
    input  wire logic [twcm_pkg::COLOR_W-1:0]       s_texel_value,
    input  wire logic [twcm_pkg::COLUMN_W-1:0]      s_column,
    input  wire logic                               s_hit_side,
    input  wire logic                               s_dir_positive,
    input  wire logic [twcm_pkg::FRAC_W-1:0]        s_wall_frac,
    input  wire logic [twcm_pkg::COLUMN_W-1:0]      s_draw_start,
    input  wire logic [twcm_pkg::ROW_W-1:0]         s_draw_end,
    input  wire logic [twcm_pkg::LINE_H_W-1:0]      s_wall_height,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [twcm_pkg::COLUMN_W-1:0]           m_pixel_x,
    output logic [twcm_pkg::PIX_Y_W-1:0]            m_pixel_y,
    output logic [twcm_pkg::COLOR_W-1:0]            m_pixel_color,
    output logic                                    m_last_pixel
);

    import twcm_pkg::*;

    localparam int STEP_W = TEX_LOG2 + 17;
    localparam int ADDR_W = TEX_SEL_W + 2 * TEX_LOG2;
    localparam int DEPTH  = NUM_TEXTURES << (2 * TEX_LOG2);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_MUL  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [SCREEN_H_W-1:0] screen_h_reg;
    logic                  strip_active_reg;
    logic [COLUMN_W-1:0]   strip_column_reg;
    logic [ROW_W-1:0]      strip_row_reg;
    logic [ROW_W-1:0]      strip_end_reg;
    logic [TEX_SEL_W-1:0]  chosen_tex_reg;
    logic [TEX_LOG2-1:0]   tex_col_reg;
    logic                  shade_on_reg;
    logic [STEP_W-1:0]     row_step_reg;
    logic [POS_W-1:0]      row_position_reg;
    logic [OFF_W-1:0]      off_reg;

    logic                  p1_valid_reg;
    logic [COLUMN_W-1:0]   p1_x_reg;
    logic [PIX_Y_W-1:0]    p1_y_reg;
    logic                  p1_last_reg;
    logic                  p1_shade_reg;

    logic                  m_valid_reg;
    logic [COLUMN_W-1:0]   m_x_reg;
    logic [PIX_Y_W-1:0]    m_y_reg;
    logic [COLOR_W-1:0]    m_color_reg;
    logic                  m_last_reg;

    logic                  s_fire;
    logic                  load_fire;
    logic                  start_fire;
    logic                  pix_fire;
    logic                  out_stall;
    logic                  p1_advance;

    logic [LINE_H_W-1:0]   lh_eff;
    logic [TEX_LOG2-1:0]   frac_col;
    logic [OFF_W-1:0]      off_next;
    logic [ROW_W:0]        row_inc;
    logic                  pix_last;
    logic [TEX_LOG2-1:0]   tex_row;
    logic [POS_W-1:0]      pos_start;

    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [COLOR_W-1:0]    rd_data;

    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic [STEP_W-1:0]     div_quotient;

    assign out_stall  = m_valid_reg && !m_ready;
    assign p1_advance = p1_valid_reg && !out_stall;
    assign s_ready    = (state_reg == ST_IDLE) && !(p1_valid_reg && out_stall);
    assign s_fire     = s_valid && s_ready;
    assign load_fire  = s_fire && (s_opcode == OP_LOAD);
    assign start_fire = s_fire && (s_opcode == OP_START);
    assign pix_fire   = s_fire && (s_opcode == OP_PIXEL) && strip_active_reg;

    assign lh_eff   = (s_wall_height == '0) ? LINE_H_W'(1) : s_wall_height;
    assign frac_col = s_wall_frac[FRAC_W-1 -: TEX_LOG2];
    assign off_next = OFF_W'(s_draw_start) - OFF_W'(screen_h_reg[SCREEN_H_W-1:1])
                      + OFF_W'(lh_eff[LINE_H_W-1:1]);

    assign row_inc  = {1'b0, strip_row_reg} + 1'b1;
    assign pix_last = row_inc >= {1'b0, strip_end_reg};
    assign tex_row  = row_position_reg[POS_FRAC_W +: TEX_LOG2];

    assign pos_start = POS_W'($signed(off_reg) * $signed({1'b0, row_step_reg}));

    assign wr_addr = {s_texture_select, TEX_LOG2'(s_texel_row), TEX_LOG2'(s_texel_col)};
    assign rd_addr = {chosen_tex_reg, tex_row, tex_col_reg};

    assign div_req.start   = start_fire;
    assign div_req.divisor = lh_eff;

    twcm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_tex_ram (
        .aclk    (aclk),
        .wr_en   (load_fire),
        .wr_addr (wr_addr),
        .wr_data (s_texel_value),
        .rd_en   (pix_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    twcm_div #(
        .TEX_LOG2 (TEX_LOG2)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .rsp      (div_rsp),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_fire) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            screen_h_reg     <= SCREEN_H_RESET;
            strip_active_reg <= 1'b0;
            p1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                screen_h_reg <= cfg_wr_data;
            end
            if (start_fire) begin
                strip_active_reg <= {1'b0, s_draw_start} < s_draw_end;
            end else if (pix_fire && pix_last) begin
                strip_active_reg <= 1'b0;
            end
            if (pix_fire) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_advance) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_fire) begin
            chosen_tex_reg   <= s_hit_side ? (s_dir_positive ? TEX_SOUTH : TEX_NORTH)
                                           : (s_dir_positive ? TEX_WEST  : TEX_EAST);
            shade_on_reg     <= !s_dir_positive;
            tex_col_reg      <= (s_hit_side ^ s_dir_positive) ? ~frac_col : frac_col;
            strip_column_reg <= s_column;
            strip_row_reg    <= ROW_W'(s_draw_start);
            strip_end_reg    <= s_draw_end;
            off_reg          <= off_next;
        end else if (pix_fire) begin
            strip_row_reg <= row_inc[ROW_W-1:0];
        end
        if (state_reg == ST_DIV && div_rsp.done) begin
            row_step_reg <= div_quotient;
        end
        if (state_reg == ST_MUL) begin
            row_position_reg <= pos_start;
        end else if (pix_fire) begin
            row_position_reg <= row_position_reg + POS_W'(row_step_reg);
        end
        if (pix_fire) begin
            p1_x_reg     <= strip_column_reg;
            p1_y_reg     <= strip_row_reg[PIX_Y_W-1:0];
            p1_last_reg  <= pix_last;
            p1_shade_reg <= shade_on_reg;
        end
        if (p1_advance) begin
            m_x_reg     <= p1_x_reg;
            m_y_reg     <= p1_y_reg;
            m_last_reg  <= p1_last_reg;
            m_color_reg <= p1_shade_reg ? shade_color(rd_data) : rd_data;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_color = m_color_reg;
    assign m_last_pixel  = m_last_reg;

    // a pending texel read is never lost while the output beat waits
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && out_stall |=> p1_valid_reg && $stable(p1_x_reg) && $stable(p1_y_reg))
        else $error("pending pixel dropped under stall");

    // the divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider done outside of divide state");

    // no beat is taken while the divider is busy
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> !s_ready)
        else $error("beat accepted during divide");

    // a strip ends only through a start beat or its last pixel
    a_strip_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(strip_active_reg) |-> $past(start_fire || (pix_fire && pix_last)))
        else $error("strip ended without cause");

endmodule

`default_nettype wire
